/* rtl/iarm_pkg.sv */
// Package for the interval range map: sizes, codes, and shared types.
// Used by the channel interfaces, the table cell and the top level.
package iarm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_INS,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROT,
    CM_SHL,
    CM_SHR,
    CM_INS
  } cell_mode_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] pos;
    logic             en0;
    logic             en1;
    entry_t           ins0;
    entry_t           ins1;
  } cell_cmd_t;

endpackage

/* rtl/iarm_if.sv */
// Valid/ready channel interfaces for the interval range map.
// Depends on iarm_pkg for field widths.
interface iarm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [iarm_pkg::KEY_WIDTH-1:0]     key_first;
  logic [iarm_pkg::KEY_WIDTH-1:0]     key_limit;
  logic [iarm_pkg::VALUE_WIDTH-1:0]   new_value;

  modport source (output valid, opcode, key_first, key_limit, new_value, input ready);
  modport sink   (input valid, opcode, key_first, key_limit, new_value, output ready);
endinterface

interface iarm_out_if;
  logic                               valid;
  logic                               ready;
  logic [iarm_pkg::VALUE_WIDTH-1:0]   found_value;
  logic [1:0]                         status;

  modport source (output valid, found_value, status, input ready);
  modport sink   (input valid, found_value, status, output ready);
endinterface

/* rtl/iarm_cell.sv */
// One breakpoint slot of the table chain.
// Depends on iarm_pkg; takes a broadcast command and its two neighbors.
module iarm_cell (
  input  logic                     clk,
  input  logic [iarm_pkg::IDX_W-1:0] idx,
  input  iarm_pkg::cell_cmd_t      cmd,
  input  iarm_pkg::entry_t         from_right,
  input  iarm_pkg::entry_t         from_left,
  output iarm_pkg::entry_t         q
);
  import iarm_pkg::*;

  logic [CNT_W-1:0] my_pos;
  entry_t           q_next;

  assign my_pos = CNT_W'(idx);

  // Pick the next content from the command
  always_comb begin
    q_next = q;
    unique case (cmd.mode)
      CM_HOLD: q_next = q;
      CM_ROT:  q_next = from_right;
      CM_SHL:  if (my_pos >= cmd.pos) q_next = from_right;
      CM_SHR:  if (my_pos > cmd.pos) q_next = from_left;
      CM_INS: begin
        if (cmd.en0 && my_pos == cmd.pos) q_next = cmd.ins0;
        if (cmd.en1 && my_pos == cmd.pos + CNT_W'(1)) q_next = cmd.ins1;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* rtl/interval_assign_range_map.sv */
// Interval range map: a sorted breakpoint table held in a ring of cells.
// Depends on iarm_pkg, iarm_if and iarm_cell.
//
// Every word takes one scan of the ring, in which the head cell is examined as
// the ring rotates once. A lookup, an empty range or a rejected assign passes
// from the scan through the decide state to the result state, which loads its
// result word. A carried-out assign first shifts the upper part of the table
// where needed (up to TABLE_DEPTH slots on a wide removal, up to two on
// insertion), then writes in the insert state. The input is ready again the
// cycle after the result is loaded, so one word is in work at a time. A result
// that is not yet taken holds the block until the output register frees up. A
// finished result waits in the output register while a new word is taken.
module interval_assign_range_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [iarm_pkg::VALUE_WIDTH-1:0] cfg_wdata,
  iarm_in_if.sink                          in_ch,
  iarm_out_if.source                       out_ch
);
  import iarm_pkg::*;

  state_t                 state, state_next;
  cell_cmd_t              cmd;
  entry_t                 cq [TABLE_DEPTH];
  entry_t                 head;

  logic [VALUE_WIDTH-1:0] dflt;
  logic [IDX_W-1:0]       scan_i;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       lcnt;
  logic [CNT_W-1:0]       dcnt;
  logic [CNT_W-1:0]       sh_pos;
  logic [CNT_W-1:0]       sh_cnt;
  logic                   sh_left;
  logic [CNT_W:0]         n_reg;
  logic                   op;
  logic [KEY_WIDTH-1:0]   kb, ke, probe;
  logic [VALUE_WIDTH-1:0] val, prior, at_end;
  logic [VALUE_WIDTH-1:0] res_value;
  status_t                res_status;
  logic                   ov;
  logic [VALUE_WIDTH-1:0] o_value;
  status_t                o_status;

  logic                   live;
  logic                   m0, m1;
  logic [CNT_W:0]         m_w, n_calc;
  logic                   take_out;

  // Ring of cells; cell 0 is the head
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    iarm_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(j)),
      .cmd        (cmd),
      .from_right (cq[(j + 1) % TABLE_DEPTH]),
      .from_left  (cq[(j + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .q          (cq[j])
    );
  end

  assign head = cq[0];
  assign live = CNT_W'(scan_i) < count;

  // Decision terms from the finished scan
  assign m0     = prior != val;
  assign m1     = at_end != val;
  assign m_w    = (CNT_W+1)'(m0) + (CNT_W+1)'(m1);
  assign n_calc = (CNT_W+1)'(count) - (CNT_W+1)'(dcnt) + m_w;

  assign in_ch.ready   = state == S_IDLE;
  assign take_out      = !ov || out_ch.ready;
  assign out_ch.valid  = ov;
  assign out_ch.found_value = o_value;
  assign out_ch.status = o_status;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_ch.valid) state_next = S_SCAN;
      S_SCAN:   if (scan_i == IDX_W'(TABLE_DEPTH - 1)) state_next = S_DECIDE;
      S_DECIDE: begin
        priority if (op == OP_LOOKUP || kb >= ke || n_calc > (CNT_W+1)'(TABLE_DEPTH))
          state_next = S_RESP;
        else if (m_w != (CNT_W+1)'(dcnt))
          state_next = S_SHIFT;
        else
          state_next = S_INS;
      end
      S_SHIFT:  if (sh_cnt == CNT_W'(1)) state_next = S_INS;
      S_INS:    state_next = S_RESP;
      S_RESP:   if (take_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Cell command
  always_comb begin
    cmd      = '0;
    cmd.mode = CM_HOLD;
    cmd.ins0 = m0 ? entry_t'{key: kb, value: val} : entry_t'{key: ke, value: at_end};
    cmd.ins1 = entry_t'{key: ke, value: at_end};
    unique case (state)
      S_SCAN:  cmd.mode = CM_ROT;
      S_SHIFT: begin
        cmd.mode = sh_left ? CM_SHL : CM_SHR;
        cmd.pos  = sh_pos;
      end
      S_INS: begin
        cmd.mode = CM_INS;
        cmd.pos  = lcnt;
        cmd.en0  = m0 || m1;
        cmd.en1  = m0 && m1;
      end
      default: cmd.mode = CM_HOLD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dflt  <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) dflt <= cfg_wdata;
      if (state == S_INS) count <= n_reg[CNT_W-1:0];
      // Load the result word, or drop it once taken
      if (state == S_RESP && take_out) ov <= 1'b1;
      else if (out_ch.ready) ov <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op     <= in_ch.opcode;
        kb     <= in_ch.key_first;
        ke     <= in_ch.key_limit;
        val    <= in_ch.new_value;
        probe  <= (in_ch.opcode == OP_LOOKUP) ? in_ch.key_first : in_ch.key_limit;
        prior  <= dflt;
        at_end <= dflt;
        lcnt   <= '0;
        dcnt   <= '0;
        scan_i <= '0;
      end
      S_SCAN: begin
        scan_i <= scan_i + IDX_W'(1);
        if (live) begin
          if (head.key < kb) begin
            prior <= head.value;
            lcnt  <= lcnt + CNT_W'(1);
          end
          if (head.key <= probe) at_end <= head.value;
          if (head.key >= kb && head.key <= ke) dcnt <= dcnt + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        n_reg     <= n_calc;
        res_value <= (op == OP_LOOKUP) ? at_end : '0;
        priority if (op == OP_LOOKUP) begin
          res_status <= ST_DONE;
        end else if (kb >= ke) begin
          res_status <= ST_EMPTY;
        end else if (n_calc > (CNT_W+1)'(TABLE_DEPTH)) begin
          res_status <= ST_FULL;
        end else if ((CNT_W+1)'(dcnt) > m_w) begin
          res_status <= ST_DONE;
          sh_left    <= 1'b1;
          sh_pos     <= lcnt + CNT_W'(m_w);
          sh_cnt     <= dcnt - CNT_W'(m_w);
        end else begin
          res_status <= ST_DONE;
          sh_left    <= 1'b0;
          sh_pos     <= lcnt + dcnt;
          sh_cnt     <= CNT_W'(m_w) - dcnt;
        end
      end
      S_SHIFT: sh_cnt <= sh_cnt - CNT_W'(1);
      S_RESP: begin
        if (take_out) begin
          o_value  <= res_value;
          o_status <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule
